### rtl/integer_to_ascii_formatter_macros.svh
// Assertion macros for the integer to ASCII formatter.
// No dependencies; the modules that assert include this file.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ITAF_ASSERT_SAME(name, clock, rstn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ITAF_ASSERT_NEXT(name, clock, rstn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/itaf_pkg.sv
// Package for the integer to ASCII formatter: mode codes, prefix codes,
// cell control type and character lookup functions. No dependencies.
package itaf_pkg;

    localparam int POINTER_BITS_DEF = 64;
    localparam int DEC_DIGITS       = 10;
    localparam int DEC_BITS         = 32;

    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_HEXL = 3'd2;
    localparam logic [2:0] MODE_HEXU = 3'd3;
    localparam logic [2:0] MODE_PTR  = 3'd4;

    localparam logic [1:0] PFX_MINUS = 2'd0;
    localparam logic [1:0] PFX_HEX   = 2'd1;
    localparam logic [1:0] PFX_NIL   = 2'd2;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (d < 4'd10)
            digit_char = 8'h30 + {4'd0, d};
        else
            digit_char = base + {4'd0, d} - 8'd10;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h30;
        case (kind)
            PFX_MINUS: ch = 8'h2d;
            PFX_HEX:   ch = (idx == 3'd0) ? 8'h30 : 8'h78;
            PFX_NIL:
            begin
                case (idx)
                    3'd0:    ch = 8'h28;
                    3'd1:    ch = 8'h6e;
                    3'd2:    ch = 8'h69;
                    3'd3:    ch = 8'h6c;
                    default: ch = 8'h29;
                endcase
            end
            default: ch = 8'h30;
        endcase
        prefix_char = ch;
    endfunction

endpackage

### rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: control, prefix text and the
// row of digit cells. Depends on itaf_pkg, itaf_cell and the macro header.
//
// Prints one value per item as %d, %u, %x, %X or %p text, one character per
// result item, most significant first, with a wrapping 32-bit count of all
// characters so far on every result. One item is worked at a time; a new
// item is taken once the last character of the previous one has gone into
// the output register. Hex and pointer values load straight into the digit
// cells; decimal values go through a shift-and-add-3 conversion of all 32
// bits across the cells. Leading zeros are then dropped one cell shift per
// cycle, up to NCELL-1 of them (NCELL = max(10, ceil(POINTER_BITS/4)),
// 16 by default), and the characters leave at one per cycle while the
// output is not stalled. For a pointer, "0x" holds back the first digit;
// a null pointer prints "(nil)". Prefix text (minus sign, "0x") goes out
// while the cells still convert or drop zeros. Modes 5 to 7 are taken and
// dropped with no result.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
    parameter int POINTER_BITS = itaf_pkg::POINTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  mode,
    input  logic [63:0] value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  char_out,
    output logic        last_char,
    output logic [31:0] total_chars
);
    import itaf_pkg::*;

    localparam int PTR_DIGITS = (POINTER_BITS + 3) / 4;
    localparam int NCELL      = (PTR_DIGITS > DEC_DIGITS) ? PTR_DIGITS : DEC_DIGITS;
    localparam int REM_W      = $clog2(NCELL + 1);
    localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - POINTER_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_NIL  = 3'd4;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [4:0]       bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [1:0]       pfx_kind_reg, pfx_kind_next;
    logic [2:0]       pfx_idx_reg, pfx_idx_next;
    logic [2:0]       pfx_end_reg, pfx_end_next;
    logic             upper_reg, upper_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload
    logic [31:0]      work_reg, work_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [31:0]      total_reg, total_next;

    logic             accept;
    logic             mode_ok;
    logic             is_dec;
    logic [31:0]      low32;
    logic [31:0]      mag32;
    logic [63:0]      ptr_val;
    logic [63:0]      load_src;
    logic             out_free;
    logic             pfx_active;
    logic             pfx_emit;
    logic             dig_emit;
    logic             skip_shift;
    logic             emit_any;
    cell_ctrl_t       cell_ctrl;

    logic [3:0]       cell_digit [NCELL];
    logic             cell_bit   [NCELL];
    logic [3:0]       load_nib   [NCELL];
    logic [3:0]       top_digit;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign mode_ok   = (mode <= MODE_PTR);
    assign is_dec    = (mode == MODE_SDEC) || (mode == MODE_UDEC);
    assign low32     = value[31:0];
    assign mag32     = 32'd0 - low32;
    assign ptr_val   = value & PTR_MASK;
    assign load_src  = (mode == MODE_PTR) ? ptr_val : {32'd0, low32};
    assign top_digit = cell_digit[NCELL-1];

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign pfx_active = (pfx_idx_reg != pfx_end_reg);
    // Prefix text goes first; digits wait until it is done
    assign pfx_emit   = pfx_active && out_free;
    assign dig_emit   = (state_reg == S_EMIT) && !pfx_active && out_free;
    assign skip_shift = (state_reg == S_SKIP) && (top_digit == 4'd0) && (rem_reg > REM_W'(1));
    assign emit_any   = pfx_emit || dig_emit;

    assign cell_ctrl.load   = accept && mode_ok;
    assign cell_ctrl.dabble = (state_reg == S_CONV);
    assign cell_ctrl.shift  = skip_shift || dig_emit;

    // Row of digit cells, cell NCELL-1 holds the most significant digit
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            logic       bit_in_w;
            logic [3:0] digit_in_w;

            assign load_nib[gi] = is_dec ? 4'd0 : load_src[4*gi +: 4];

            if (gi == 0)
            begin : g_first
                assign bit_in_w   = work_reg[DEC_BITS-1];
                assign digit_in_w = 4'd0;
            end
            else
            begin : g_rest
                assign bit_in_w   = cell_bit[gi-1];
                assign digit_in_w = cell_digit[gi-1];
            end

            itaf_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .load_digit (load_nib[gi]),
                .bit_in     (bit_in_w),
                .digit_in   (digit_in_w),
                .bit_out    (cell_bit[gi]),
                .digit      (cell_digit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        rem_next      = rem_reg;
        pfx_kind_next = pfx_kind_reg;
        pfx_idx_next  = pfx_idx_reg;
        pfx_end_next  = pfx_end_reg;
        upper_next    = upper_reg;
        work_next     = work_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode_ok)
                begin
                    bit_cnt_next = 5'd0;
                    rem_next     = REM_W'(NCELL);
                    upper_next   = (mode == MODE_HEXU);
                    pfx_idx_next = 3'd0;
                    pfx_end_next = 3'd0;
                    work_next    = low32;
                    case (mode)
                        MODE_SDEC:
                        begin
                            state_next = S_CONV;
                            if (low32[31])
                            begin
                                work_next     = mag32;
                                pfx_kind_next = PFX_MINUS;
                                pfx_end_next  = 3'd1;
                            end
                        end
                        MODE_UDEC:
                            state_next = S_CONV;
                        MODE_PTR:
                        begin
                            if (ptr_val == 64'd0)
                            begin
                                state_next    = S_NIL;
                                pfx_kind_next = PFX_NIL;
                                pfx_end_next  = 3'd5;
                            end
                            else
                            begin
                                state_next    = S_SKIP;
                                pfx_kind_next = PFX_HEX;
                                pfx_end_next  = 3'd2;
                            end
                        end
                        default:
                            state_next = S_SKIP;
                    endcase
                end
            end
            S_CONV:
            begin
                // Feed one bit per cycle into the cells, MSB first
                work_next    = {work_reg[DEC_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(DEC_BITS - 1))
                    state_next = S_SKIP;
            end
            S_SKIP:
            begin
                // Drop one leading zero per cycle, keep at least one digit
                if (skip_shift)
                    rem_next = rem_reg - REM_W'(1);
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (dig_emit)
                begin
                    rem_next = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                        state_next = S_IDLE;
                end
            end
            S_NIL:
            begin
                if (pfx_emit && (pfx_idx_reg == pfx_end_reg - 3'd1))
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (pfx_emit)
            pfx_idx_next = pfx_idx_reg + 3'd1;
    end

    // Output register: load on each emitted character, clear when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        if (emit_any)
        begin
            rsp_valid_next = 1'b1;
            cnt_next       = cnt_reg + 32'd1;
            total_next     = cnt_reg + 32'd1;
            if (pfx_emit)
            begin
                char_next = prefix_char(pfx_kind_reg, pfx_idx_reg);
                last_next = (state_reg == S_NIL) && (pfx_idx_reg == pfx_end_reg - 3'd1);
            end
            else
            begin
                char_next = digit_char(top_digit, upper_reg);
                last_next = (rem_reg == REM_W'(1));
            end
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            pfx_kind_reg  <= PFX_MINUS;
            pfx_idx_reg   <= '0;
            pfx_end_reg   <= '0;
            upper_reg     <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            pfx_kind_reg  <= pfx_kind_next;
            pfx_idx_reg   <= pfx_idx_next;
            pfx_end_reg   <= pfx_end_next;
            upper_reg     <= upper_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        total_reg <= total_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign char_out    = char_reg;
    assign last_char   = last_reg;
    assign total_chars = total_reg;

    `ITAF_ASSERT_NEXT(a_count_step, clk, rst_n, emit_any,
        total_reg == cnt_reg, "reported total does not match character count")
    `ITAF_ASSERT_SAME(a_rem_nonzero, clk, rst_n,
        (state_reg == S_SKIP) || (state_reg == S_EMIT),
        rem_reg != REM_W'(0), "digit count ran out before the last digit")
    `ITAF_ASSERT_NEXT(a_last_idle, clk, rst_n, emit_any && last_next,
        state_reg == S_IDLE, "last character sent but item still in progress")
    `ITAF_ASSERT_SAME(a_no_digit_during_prefix, clk, rst_n,
        (state_reg == S_CONV) || (state_reg == S_NIL),
        !dig_emit, "digit emitted before conversion finished")

endmodule

### rtl/itaf_cell.sv
// One digit cell of the formatter's digit chain.
// Depends on itaf_pkg (cell control type).
module itaf_cell (
    input  logic                   clk,
    input  itaf_pkg::cell_ctrl_t   ctrl,
    input  logic [3:0]             load_digit,
    input  logic                   bit_in,
    input  logic [3:0]             digit_in,
    output logic                   bit_out,
    output logic [3:0]             digit
);
    import itaf_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add-3 correction before each doubling step
    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load)
            digit_next = load_digit;
        else if (ctrl.dabble)
            digit_next = {adj[2:0], bit_in};
        else if (ctrl.shift)
            digit_next = digit_in;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
